### hw/rtl/clvd_pkg.sv
// Shared constants, codes and types of the chunked length-value decoder.
// No dependencies; the core, the checker and the testbench import this package.
package clvd_pkg;

    // Widest count prefix of one chunk, in bytes
    localparam int COUNT_BYTES_MAX = 4;
    localparam int CNT_W           = $clog2(COUNT_BYTES_MAX + 1);

    // Result buffer depth; one request may push two results
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_VALUE_SIZE = 2'd0;
    localparam logic [1:0] REG_NULL_CODE      = 2'd1;
    localparam logic [1:0] REG_LONG_CODE      = 2'd2;

    // Configuration reset values
    localparam logic [31:0] MAX_VALUE_SIZE_RST = 32'd65535;
    localparam logic [7:0]  NULL_CODE_RST      = 8'd255;
    localparam logic [7:0]  LONG_CODE_RST      = 8'd254;

    // Parser phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SHORT  = 3'd1;
    localparam logic [2:0] PH_CLEN   = 3'd2;
    localparam logic [2:0] PH_CBYTES = 3'd3;
    localparam logic [2:0] PH_CHUNK  = 3'd4;

    // Result kinds
    localparam logic [2:0] K_PAYLOAD = 3'd0;
    localparam logic [2:0] K_DONE    = 3'd1;
    localparam logic [2:0] K_NULL    = 3'd2;
    localparam logic [2:0] K_TRUNC   = 3'd3;
    localparam logic [2:0] K_NEG     = 3'd4;
    localparam logic [2:0] K_WIDE    = 3'd5;
    localparam logic [2:0] K_LIMIT   = 3'd6;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    // Build one result; non-payload kinds carry a zero byte and close the value
    function automatic t_result mk_result(input logic [2:0] kind, input logic [7:0] data);
        t_result r;
        r.kind = kind;
        r.data = (kind == K_PAYLOAD) ? data : 8'd0;
        r.last = (kind != K_PAYLOAD);
        return r;
    endfunction

endpackage

### hw/rtl/clvd_ifs.sv
// Valid/ready channel interfaces of the chunked length-value decoder.
// No dependencies; the field widths match clvd_pkg, but the file does not import it.

interface clvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface clvd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       value_end;

    modport source (output valid, output out_kind, output out_byte, output value_end,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input value_end,
                    output ready);
endinterface

interface clvd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/chunked_length_value_decoder_core.sv
// Top level of the chunked length-value decoder: byte parser and result buffer.
// Depends on clvd_pkg and the channel interfaces in clvd_ifs.sv.

// The decoder takes one stream byte per request and turns it into zero, one
// or two results (payload byte, value done, null, or an error kind followed
// by a return to idle). Each byte is parsed in the cycle it is accepted and
// its results land in a four-entry result buffer, which drains one result per
// cycle on the output channel while it is ready. A byte is accepted whenever
// at least two buffer entries are free, so the block takes one byte per cycle
// as long as the output side keeps taking results; only bytes that yield two
// results (the last payload byte of a short value, or a payload byte that
// also flags truncation) add to the backlog. Configuration writes are taken
// every cycle and must only be issued while the decoder is idle.
module chunked_length_value_decoder_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    clvd_in_if.sink    i_in,
    clvd_out_if.source o_out,
    clvd_cfg_if.sink   i_cfg
);
    import clvd_pkg::*;

    // Configuration registers
    logic [31:0] r_max;
    logic [7:0]  r_null;
    logic [7:0]  r_long;

    // Parser state
    logic [2:0]       r_phase, n_phase;
    logic [31:0]      r_run, n_run;
    logic [31:0]      r_total, n_total;
    logic [CNT_W-1:0] r_cnt_left, n_cnt_left;
    logic [31:0]      r_accum, n_accum;

    // Result buffer
    t_result              r_buf [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [RES_CNT_W-1:0] r_cnt;

    t_result     res0, res1;
    logic [1:0]  n_res;
    logic        errored;
    logic [7:0]  b;
    logic [31:0] acc_shift;
    logic [31:0] room;
    logic        in_acc, out_acc;

    assign b         = i_in.data_byte;
    assign acc_shift = {r_accum[23:0], b};
    assign room      = r_max - r_total;

    assign i_in.ready  = (r_cnt <= RES_CNT_W'(RES_DEPTH - 2));
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = (r_cnt != '0);
    assign out_acc     = o_out.valid && o_out.ready;

    assign o_out.out_kind  = r_buf[r_rd_ptr].kind;
    assign o_out.out_byte  = r_buf[r_rd_ptr].data;
    assign o_out.value_end = r_buf[r_rd_ptr].last;

    assign i_cfg.ready = 1'b1;

    // Decode one byte against the current phase
    always_comb begin
        n_phase    = r_phase;
        n_run      = r_run;
        n_total    = r_total;
        n_cnt_left = r_cnt_left;
        n_accum    = r_accum;
        res0       = mk_result(K_NULL, 8'd0);
        res1       = mk_result(K_TRUNC, 8'd0);
        n_res      = 2'd0;
        errored    = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (b == 8'd0 || b == r_null) begin
                    res0  = mk_result(K_NULL, 8'd0);
                    n_res = 2'd1;
                end else if (b == r_long) begin
                    n_total = '0;
                    n_phase = PH_CLEN;
                end else if ({24'd0, b} > r_max) begin
                    res0    = mk_result(K_LIMIT, 8'd0);
                    n_res   = 2'd1;
                    errored = 1'b1;
                end else begin
                    n_run   = {24'd0, b};
                    n_phase = PH_SHORT;
                end
            end
            PH_SHORT: begin
                res0  = mk_result(K_PAYLOAD, b);
                n_res = 2'd1;
                n_run = r_run - 32'd1;
                if (r_run == 32'd1) begin
                    res1    = mk_result(K_DONE, 8'd0);
                    n_res   = 2'd2;
                    n_phase = PH_IDLE;
                end
            end
            PH_CLEN: begin
                if (b[7]) begin
                    res0    = mk_result(K_NEG, 8'd0);
                    n_res   = 2'd1;
                    errored = 1'b1;
                end else if (b > 8'(COUNT_BYTES_MAX)) begin
                    res0    = mk_result(K_WIDE, 8'd0);
                    n_res   = 2'd1;
                    errored = 1'b1;
                end else if (b == 8'd0) begin
                    res0    = mk_result((r_total == '0) ? K_NULL : K_DONE, 8'd0);
                    n_res   = 2'd1;
                    n_phase = PH_IDLE;
                end else begin
                    n_cnt_left = b[CNT_W-1:0];
                    n_accum    = '0;
                    n_phase    = PH_CBYTES;
                end
            end
            PH_CBYTES: begin
                n_cnt_left = r_cnt_left - CNT_W'(1);
                n_accum    = acc_shift;
                if (r_cnt_left == CNT_W'(1)) begin
                    if (acc_shift == '0) begin
                        res0    = mk_result((r_total == '0) ? K_NULL : K_DONE, 8'd0);
                        n_res   = 2'd1;
                        n_phase = PH_IDLE;
                    end else if (acc_shift > room) begin
                        res0    = mk_result(K_LIMIT, 8'd0);
                        n_res   = 2'd1;
                        errored = 1'b1;
                    end else begin
                        n_total = r_total + acc_shift;
                        n_run   = acc_shift;
                        n_phase = PH_CHUNK;
                    end
                end
            end
            default: begin
                // chunk payload
                res0  = mk_result(K_PAYLOAD, b);
                n_res = 2'd1;
                n_run = r_run - 32'd1;
                if (r_run == 32'd1) begin
                    n_phase = PH_CLEN;
                end
            end
        endcase

        // Report truncation when the message ends with the value still open
        if (!errored && i_in.is_last && n_phase != PH_IDLE) begin
            if (n_res == 2'd0) begin
                res0 = mk_result(K_TRUNC, 8'd0);
            end else begin
                res1 = mk_result(K_TRUNC, 8'd0);
            end
            n_res   = n_res + 2'd1;
            n_phase = PH_IDLE;
        end

        // Drop all value state on return to idle
        if (errored || n_phase == PH_IDLE) begin
            n_phase    = PH_IDLE;
            n_run      = '0;
            n_total    = '0;
            n_cnt_left = '0;
            n_accum    = '0;
        end
    end

    // Configuration writes; indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= MAX_VALUE_SIZE_RST;
            r_null <= NULL_CODE_RST;
            r_long <= LONG_CODE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_VALUE_SIZE: r_max  <= i_cfg.data;
                REG_NULL_CODE:      r_null <= i_cfg.data[7:0];
                REG_LONG_CODE:      r_long <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Advance parser state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_run      <= '0;
            r_total    <= '0;
            r_cnt_left <= '0;
            r_accum    <= '0;
        end else if (in_acc) begin
            r_phase    <= n_phase;
            r_run      <= n_run;
            r_total    <= n_total;
            r_cnt_left <= n_cnt_left;
            r_accum    <= n_accum;
        end
    end

    // Push results of the accepted byte into the buffer
    always_ff @(posedge i_clk) begin
        if (in_acc && n_res != 2'd0) begin
            r_buf[r_wr_ptr] <= res0;
        end
        if (in_acc && n_res == 2'd2) begin
            r_buf[r_wr_ptr + RES_PTR_W'(1)] <= res1;
        end
    end

    // Track buffer pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + RES_PTR_W'(n_res);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            r_cnt <= r_cnt + (in_acc ? RES_CNT_W'(n_res) : '0) - RES_CNT_W'(out_acc);
        end
    end

endmodule

### hw/rtl/clvd_checker.sv
// Port-level checker of the chunked length-value decoder and its bind.
// Depends on clvd_pkg; attaches to chunked_length_value_decoder_core.
module clvd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_kind,
    input logic [7:0] i_out_byte,
    input logic       i_value_end
);
    import clvd_pkg::*;

    // Hold the result while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_byte)
            && $stable(i_value_end))
        else $error("output result changed under stall");

    // Only payload results leave the value open
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_value_end == (i_out_kind != K_PAYLOAD)))
        else $error("value_end does not match result kind");

    // Non-payload results carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != K_PAYLOAD |-> i_out_byte == 8'd0)
        else $error("non-payload result with nonzero byte");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented after reset");

endmodule

bind chunked_length_value_decoder_core clvd_checker u_clvd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.out_kind),
    .i_out_byte  (o_out.out_byte),
    .i_value_end (o_out.value_end)
);

### tb/chunked_length_value_decoder_core_tb.sv
// Self-checking testbench of chunked_length_value_decoder_core: a directed table,
// then random byte streams over several register settings and idle patterns.
// Depends on clvd_pkg, the channel interfaces in clvd_ifs.sv and the core itself.
module chunked_length_value_decoder_core_tb;
    import clvd_pkg::*;

    // One directed row: a register setting, or a stream byte with optional typed results
    typedef struct {
        bit          is_settings;
        logic [31:0] max_val;
        logic [7:0]  null_val;
        logic [7:0]  long_val;
        logic [7:0]  data;
        logic        fin;
        int          n_typed;   // below zero: results come from the decoder model
        t_result     want0;
        t_result     want1;
    } t_dir_row;

    logic clk;
    logic rst_n;

    clvd_in_if  in_if ();
    clvd_out_if out_if ();
    clvd_cfg_if cfg_if ();

    chunked_length_value_decoder_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Register copies and parser state of the decoder model
    logic [31:0] cfg_max;
    logic [7:0]  cfg_null;
    logic [7:0]  cfg_long;
    logic [2:0]  ps_phase;
    logic [31:0] ps_run;
    logic [31:0] ps_total;
    logic [2:0]  ps_cnt_left;
    logic [31:0] ps_accum;

    t_result     dec_res [2];
    int          dec_n;
    t_result     expected_results [$];
    t_dir_row    pending_bytes [$];

    int unsigned in_count;
    int unsigned cfg_count;
    int unsigned err_cnt;
    int unsigned send_gap_pct;
    int unsigned stall_pct;

    t_dir_row    dir_rows [$];

    // Decoder model -------------------------------------------------------------

    function automatic void note_result(logic [2:0] kind, logic [7:0] data, logic fin);
        dec_res[dec_n].kind = kind;
        dec_res[dec_n].data = data;
        dec_res[dec_n].last = fin;
        dec_n++;
    endfunction

    function automatic void clear_state();
        ps_phase    = PH_IDLE;
        ps_run      = '0;
        ps_total    = '0;
        ps_cnt_left = '0;
        ps_accum    = '0;
    endfunction

    // Close a chunked value: null when no payload came, else done
    function automatic void close_value();
        note_result((ps_total == 0) ? K_NULL : K_DONE, 8'd0, 1'b1);
        clear_state();
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic fin);
        logic err;
        err   = 1'b0;
        dec_n = 0;
        case (ps_phase)
            PH_IDLE: begin
                if (b == 8'd0 || b == cfg_null) begin
                    note_result(K_NULL, 8'd0, 1'b1);
                end else if (b == cfg_long) begin
                    ps_total = '0;
                    ps_phase = PH_CLEN;
                end else if ({24'd0, b} > cfg_max) begin
                    note_result(K_LIMIT, 8'd0, 1'b1);
                    err = 1'b1;
                end else begin
                    ps_run   = {24'd0, b};
                    ps_phase = PH_SHORT;
                end
            end
            PH_SHORT: begin
                note_result(K_PAYLOAD, b, 1'b0);
                ps_run = ps_run - 32'd1;
                if (ps_run == 0) begin
                    note_result(K_DONE, 8'd0, 1'b1);
                    clear_state();
                end
            end
            PH_CLEN: begin
                if (b[7]) begin
                    note_result(K_NEG, 8'd0, 1'b1);
                    err = 1'b1;
                end else if (b > COUNT_BYTES_MAX) begin
                    note_result(K_WIDE, 8'd0, 1'b1);
                    err = 1'b1;
                end else if (b == 8'd0) begin
                    close_value();
                end else begin
                    ps_cnt_left = b[2:0];
                    ps_accum    = '0;
                    ps_phase    = PH_CBYTES;
                end
            end
            PH_CBYTES: begin
                ps_accum    = {ps_accum[23:0], b};
                ps_cnt_left = ps_cnt_left - 3'd1;
                if (ps_cnt_left == 0) begin
                    if (ps_accum == 0) begin
                        close_value();
                    end else if (ps_accum > cfg_max - ps_total) begin
                        note_result(K_LIMIT, 8'd0, 1'b1);
                        err = 1'b1;
                    end else begin
                        ps_total = ps_total + ps_accum;
                        ps_run   = ps_accum;
                        ps_phase = PH_CHUNK;
                    end
                end
            end
            default: begin
                note_result(K_PAYLOAD, b, 1'b0);
                ps_run = ps_run - 32'd1;
                if (ps_run == 0) ps_phase = PH_CLEN;
            end
        endcase
        // Drop back to idle on error; flag truncation if the message ends mid-value
        if (err) begin
            clear_state();
        end else if (fin && ps_phase != PH_IDLE) begin
            note_result(K_TRUNC, 8'd0, 1'b1);
            clear_state();
        end
    endfunction

    // Append one expected result
    function automatic void add_want(t_result r);
        expected_results = {expected_results, r};
    endfunction

    // Directed table helpers ----------------------------------------------------

    function automatic t_dir_row byte_row(logic [7:0] d, logic fin);
        t_dir_row r;
        r             = '{default: '0};
        r.data        = d;
        r.fin         = fin;
        r.n_typed     = -1;
        return r;
    endfunction

    function automatic t_dir_row typed_row(logic [7:0] d, logic fin, int n,
                                           logic [2:0] k0, logic [7:0] b0, logic e0,
                                           logic [2:0] k1, logic [7:0] b1, logic e1);
        t_dir_row r;
        r            = byte_row(d, fin);
        r.n_typed    = n;
        r.want0.kind = k0;
        r.want0.data = b0;
        r.want0.last = e0;
        r.want1.kind = k1;
        r.want1.data = b1;
        r.want1.last = e1;
        return r;
    endfunction

    function automatic t_dir_row settings_row(logic [31:0] mx, logic [7:0] nc, logic [7:0] lc);
        t_dir_row r;
        r             = '{default: '0};
        r.is_settings = 1'b1;
        r.max_val     = mx;
        r.null_val    = nc;
        r.long_val    = lc;
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_dir_row r);
        dir_rows = {dir_rows, r};
    endfunction

    // Clock and reset -----------------------------------------------------------

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: stall at random with the current stall rate
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_if.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: track register writes, predict accepted requests, check results
    always @(posedge clk) begin : monitor
        t_result  got;
        t_result  want;
        t_dir_row row;
        int       k;
        if (!rst_n) begin
            cfg_max  = MAX_VALUE_SIZE_RST;
            cfg_null = NULL_CODE_RST;
            cfg_long = LONG_CODE_RST;
            clear_state();
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_MAX_VALUE_SIZE: cfg_max  = cfg_if.data;
                    REG_NULL_CODE:      cfg_null = cfg_if.data[7:0];
                    REG_LONG_CODE:      cfg_long = cfg_if.data[7:0];
                    default: ;
                endcase
                cfg_count++;
            end
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.data_byte, in_if.is_last);
                row = pending_bytes.pop_front();
                if (row.n_typed < 0) begin
                    for (k = 0; k < dec_n; k++) add_want(dec_res[k]);
                end else begin
                    if (row.n_typed > 0) add_want(row.want0);
                    if (row.n_typed > 1) add_want(row.want1);
                end
                in_count++;
            end
            if (out_if.valid && out_if.ready) begin
                got.kind = out_if.out_kind;
                got.data = out_if.out_byte;
                got.last = out_if.value_end;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: out_kind %0d out_byte %0h value_end %0b",
                           got.kind, got.data, got.last);
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
                        err_cnt++;
                    end
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, got.data);
                        err_cnt++;
                    end
                    if (got.last !== want.last) begin
                        $error("value_end: expected %0b, got %0b", want.last, got.last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Driver tasks ----------------------------------------------------------------

    // Present one stream byte, with random gaps first; return on the negedge after accept
    task automatic send_byte(input t_dir_row row);
        int unsigned seen;
        while ($urandom_range(99) < send_gap_pct) begin
            in_if.valid     = 1'b0;
            in_if.data_byte = 8'($urandom);
            in_if.is_last   = 1'($urandom);
            @(negedge clk);
        end
        pending_bytes   = {pending_bytes, row};
        in_if.valid     = 1'b1;
        in_if.data_byte = row.data;
        in_if.is_last   = row.fin;
        seen = in_count;
        do @(negedge clk); while (in_count == seen);
    endtask

    // Hold until every expected result is out and the parser has settled
    task automatic wait_drained();
        while (expected_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write all three registers back to back, valid held high across them
    task automatic write_settings(logic [31:0] mx, logic [7:0] nc, logic [7:0] lc);
        logic [31:0] vals [3];
        int unsigned seen;
        int          i;
        vals[0] = mx;
        vals[1] = {24'd0, nc};
        vals[2] = {24'd0, lc};
        for (i = 0; i < 3; i++) begin
            cfg_if.valid = 1'b1;
            cfg_if.index = (i == 0) ? REG_MAX_VALUE_SIZE :
                           (i == 1) ? REG_NULL_CODE : REG_LONG_CODE;
            cfg_if.data  = vals[i];
            seen = cfg_count;
            do @(negedge clk); while (cfg_count == seen);
        end
        cfg_if.valid = 1'b0;
    endtask

    // Build one random value (mostly well formed), maybe cut short, and send it
    task automatic send_random_value();
        logic [7:0]  v [$];
        logic [31:0] cnt;
        logic [31:0] room;
        logic [7:0]  b;
        int unsigned pick;
        int unsigned len;
        int unsigned width;
        int unsigned nchunks;
        int          last_at;
        int          cut;
        int          i;
        int          j;
        bit          stop;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise byte
            v = {v, 8'($urandom)};
        end else if (pick < 20) begin
            v = {v, ((pick < 15) ? 8'd0 : cfg_null)};
        end else if (pick < 55) begin
            // short form, mostly small lengths
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
            b   = 8'(len);
            v   = {v, b};
            if (b != cfg_null && b != cfg_long && len <= cfg_max)
                repeat (len) v = {v, 8'($urandom)};
        end else begin
            // chunked form
            v       = {v, cfg_long};
            room    = cfg_max;
            nchunks = $urandom_range(0, 3);
            stop    = 1'b0;
            for (i = 0; i < nchunks && !stop; i++) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    v    = {v, (8'h80 | 8'($urandom))};
                    stop = 1'b1;
                end else if (pick < 10) begin
                    v    = {v, 8'($urandom_range(COUNT_BYTES_MAX + 1, 127))};
                    stop = 1'b1;
                end else begin
                    width = $urandom_range(1, COUNT_BYTES_MAX);
                    cnt   = (pick < 25) ? $urandom : $urandom_range(1, 6);
                    cnt   = cnt >> (8 * (4 - width));
                    if (cnt == 0) cnt = 1;
                    // keep accepted chunks short; oversize only where it overflows
                    if (cnt > 6 && cnt <= room) cnt = $urandom_range(1, 6);
                    v = {v, 8'(width)};
                    for (j = width - 1; j >= 0; j--) v = {v, cnt[8*j +: 8]};
                    if (cnt > room) begin
                        stop = 1'b1;
                    end else begin
                        room = room - cnt;
                        repeat (cnt) v = {v, 8'($urandom)};
                    end
                end
            end
            // zero count closes the value
            if (!stop) begin
                if ($urandom_range(1) == 0) begin
                    v = {v, 8'd0};
                end else begin
                    width = $urandom_range(1, COUNT_BYTES_MAX);
                    v     = {v, 8'(width)};
                    repeat (width) v = {v, 8'd0};
                end
            end
        end
        // End the message mid-value now and then, or on the closing byte
        last_at = -1;
        pick    = $urandom_range(99);
        if (pick < 8 && v.size() > 1) begin
            cut = $urandom_range(0, v.size() - 2);
            while (v.size() > cut + 1) void'(v.pop_back());
            last_at = cut;
        end else if (pick < 23) begin
            last_at = v.size() - 1;
        end
        for (i = 0; i < v.size(); i++) send_byte(byte_row(v[i], i == last_at));
    endtask

    // Stimulus ----------------------------------------------------------------

    initial begin
        int          ph;
        int unsigned target;
        logic [31:0] mx;
        logic [7:0]  nc;
        logic [7:0]  lc;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'd0;
        in_if.is_last   = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_MAX_VALUE_SIZE;
        cfg_if.data     = 32'd0;
        rst_n           = 1'b0;
        in_count        = 0;
        cfg_count       = 0;
        err_cnt         = 0;
        send_gap_pct    = 0;
        stall_pct       = 0;

        // Directed table, reset settings first
        add_row(typed_row(8'h00, 1'b0, 1, K_NULL, 8'h00, 1'b1, K_PAYLOAD, 8'h00, 1'b0));
        add_row(typed_row(8'hFF, 1'b0, 1, K_NULL, 8'h00, 1'b1, K_PAYLOAD, 8'h00, 1'b0));
        add_row(typed_row(8'h02, 1'b0, 0, K_PAYLOAD, 8'h00, 1'b0, K_PAYLOAD, 8'h00, 1'b0));
        add_row(typed_row(8'hAA, 1'b0, 1, K_PAYLOAD, 8'hAA, 1'b0, K_PAYLOAD, 8'h00, 1'b0));
        add_row(typed_row(8'h55, 1'b0, 2, K_PAYLOAD, 8'h55, 1'b0, K_DONE, 8'h00, 1'b1));
        // negative length, too wide, empty chunk list
        add_row(byte_row(8'hFE, 1'b0));
        add_row(typed_row(8'h80, 1'b0, 1, K_NEG, 8'h00, 1'b1, K_PAYLOAD, 8'h00, 1'b0));
        add_row(byte_row(8'hFE, 1'b0));
        add_row(typed_row(8'h05, 1'b0, 1, K_WIDE, 8'h00, 1'b1, K_PAYLOAD, 8'h00, 1'b0));
        add_row(byte_row(8'hFE, 1'b0));
        add_row(typed_row(8'h00, 1'b0, 1, K_NULL, 8'h00, 1'b1, K_PAYLOAD, 8'h00, 1'b0));
        // one chunk of one byte, then a zero count
        add_row(byte_row(8'hFE, 1'b0));
        add_row(byte_row(8'h01, 1'b0));
        add_row(byte_row(8'h01, 1'b0));
        add_row(byte_row(8'h7F, 1'b0));
        add_row(byte_row(8'h00, 1'b0));
        // chunk one above the limit
        add_row(byte_row(8'hFE, 1'b0));
        add_row(byte_row(8'h03, 1'b0));
        add_row(byte_row(8'h01, 1'b0));
        add_row(byte_row(8'h00, 1'b0));
        add_row(typed_row(8'h00, 1'b0, 1, K_LIMIT, 8'h00, 1'b1, K_PAYLOAD, 8'h00, 1'b0));
        // message ends inside a short value
        add_row(byte_row(8'h03, 1'b0));
        add_row(typed_row(8'h01, 1'b1, 2, K_PAYLOAD, 8'h01, 1'b0, K_TRUNC, 8'h00, 1'b1));
        // null and long codes clash; short lengths over a tiny limit
        add_row(settings_row(32'd2, 8'd7, 8'd7));
        add_row(typed_row(8'h07, 1'b0, 1, K_NULL, 8'h00, 1'b1, K_PAYLOAD, 8'h00, 1'b0));
        add_row(typed_row(8'h03, 1'b0, 1, K_LIMIT, 8'h00, 1'b1, K_PAYLOAD, 8'h00, 1'b0));
        add_row(typed_row(8'h80, 1'b1, 1, K_LIMIT, 8'h00, 1'b1, K_PAYLOAD, 8'h00, 1'b0));

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_settings) begin
                in_if.valid = 1'b0;
                wait_drained();
                write_settings(dir_rows[i].max_val, dir_rows[i].null_val,
                               dir_rows[i].long_val);
            end else begin
                send_byte(dir_rows[i]);
            end
        end
        in_if.valid = 1'b0;

        // Random phases: each one picks an idle pattern and a register setting
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 46; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 46; end
                default: begin send_gap_pct = 36; stall_pct = 36; end
            endcase
            case (ph)
                0: begin mx = 32'd65535;      nc = 8'd255; lc = 8'd254; end
                1: begin mx = 32'd0;          nc = 8'd0;   lc = 8'd255; end
                2: begin mx = 32'hFFFF_FFFF;  nc = 8'd255; lc = 8'd0;   end
                3: begin mx = 32'd300;        nc = 8'd17;  lc = 8'd17;  end
                4: begin mx = 32'd40;         nc = 8'd128; lc = 8'd1;   end
                5: begin mx = 32'hFFFF_FFFF;  nc = 8'd200; lc = 8'd201; end
                6: begin
                    mx = $urandom_range(0, 600);
                    nc = 8'($urandom);
                    lc = 8'($urandom);
                end
                default: begin mx = 32'd1000; nc = 8'd255; lc = 8'd254; end
            endcase
            wait_drained();
            write_settings(mx, nc, lc);
            target = in_count + 229;
            while (in_count < target) send_random_value();
            // close any open value so the next register write finds the parser idle
            if (ps_phase != PH_IDLE) send_byte(byte_row(8'($urandom), 1'b1));
            in_if.valid = 1'b0;
        end

        // Drain and let the block settle before the verdict
        while (expected_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/clvd_pkg.sv
hw/rtl/clvd_ifs.sv
hw/rtl/chunked_length_value_decoder_core.sv
hw/rtl/clvd_checker.sv
tb/chunked_length_value_decoder_core_tb.sv
